// ===== sv/assert_macros.svh =====
// assertion macros for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// shared types and constants of the request deframer
// ----------------------------------------------------------------------------
package rcd_pkg;
    localparam int ARG_INDEX_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 30;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 30;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 4;

    localparam logic [1:0] CFG_INLINE = 2'd0;
    localparam logic [1:0] CFG_LOWER = 2'd1;
    localparam logic [1:0] CFG_MAXLEN = 2'd2;
    localparam logic [1:0] CFG_MAXCNT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_LARGE = 2'd3;

    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        PH_IDLE, PH_COUNT, PH_DOLLAR, PH_LEN, PH_DATA, PH_TAIL, PH_INLINE, PH_SKIP
    } phase_t;

    // byte plus its classification, passed from front to back
    typedef struct packed {
        logic [7:0] b;
        logic       is_digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_star;
        logic       is_dollar;
    } cls_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] arg_index;
        logic        arg_end;
        logic        command_end;
        logic        from_inline;
        logic [1:0]  status;
    } result_t;
endpackage

// ===== sv/rcd_front.sv =====
// ----------------------------------------------------------------------------
// rcd_front
// accepts input bytes, classifies them and queues them for the parser
// ----------------------------------------------------------------------------
module rcd_front
    import rcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    output logic      q_valid,
    input  logic      q_ready,
    output cls_item_t q_item
);
    cls_item_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cls_item_t  cls;
    logic       push, pop;

    always_comb
    begin
        cls.b = in_byte;
        cls.is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        cls.is_cr = in_byte == CH_CR;
        cls.is_lf = in_byte == CH_LF;
        cls.is_space = in_byte == CH_SPACE;
        cls.is_star = in_byte == CH_STAR;
        cls.is_dollar = in_byte == CH_DOLLAR;
    end

    assign in_ready = cnt_reg != 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = slot_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/rcd_back.sv =====
// ----------------------------------------------------------------------------
// rcd_back
// per-byte parser state machine with registered result output
// ----------------------------------------------------------------------------
module rcd_back
    import rcd_pkg::*;
#(
    parameter int ARG_INDEX_BITS = ARG_INDEX_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cls_item_t   q_item,
    input  logic        inline_enable,
    input  logic        lowercase_name,
    input  logic [29:0] max_bulk_length,
    input  logic [16:0] max_argument_count,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    localparam int AI = ARG_INDEX_BITS;
    localparam int CW = ARG_INDEX_BITS + 1;
    localparam logic [30:0] ACC_MAX = 31'h7fffffff;
    localparam logic [32:0] CNT_CAP = 33'(64'd1 << ARG_INDEX_BITS);
    localparam logic [30:0] LEN_CAP = 31'((64'd1 << LENGTH_BITS) - 1);
    localparam logic [AI-1:0] IDX_MAX = {AI{1'b1}};

    phase_t          phase_reg, phase_next;
    logic [30:0]     acc_reg, acc_next;
    logic            dseen_reg, dseen_next;
    logic [CW-1:0]   args_reg, args_next;
    logic [AI-1:0]   idx_reg, idx_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;
    logic            crp_reg, crp_next;
    logic            lhc_reg, lhc_next;
    logic            hv_reg, hv_next;
    logic [7:0]      hb_reg, hb_next;
    logic            tok_reg, tok_next;
    logic            ov_reg;
    result_t         o_reg;
    logic            emit;
    result_t         r;
    logic            step;
    logic [7:0]      b;
    logic [32:0]     climit;
    logic [30:0]     llimit;
    logic [34:0]     acc10;
    logic [15:0]     idx16;
    logic [AI-1:0]   idx_use;

    assign q_ready = !ov_reg || res_ready;
    assign step = q_valid && q_ready;
    assign b = q_item.b;
    assign res_valid = ov_reg;
    assign res = o_reg;
    assign climit = ({16'd0, max_argument_count} > CNT_CAP) ? CNT_CAP
                                                             : {16'd0, max_argument_count};
    assign llimit = ({1'b0, max_bulk_length} > LEN_CAP) ? LEN_CAP : {1'b0, max_bulk_length};
    assign acc10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {31'd0, b[3:0]};

    function automatic logic [7:0] fold(input logic [7:0] x, input logic en,
                                        input logic zero);
        if (en && zero && x >= 8'h41 && x <= 8'h5a) return x + 8'd32;
        return x;
    endfunction

    // next state
    always_comb
    begin
        phase_next = phase_reg; acc_next = acc_reg; dseen_next = dseen_reg;
        args_next = args_reg; idx_next = idx_reg; bytes_next = bytes_reg;
        crp_next = crp_reg; lhc_next = lhc_reg; hv_next = hv_reg; hb_next = hb_reg;
        tok_next = tok_reg;
        emit = 1'b0;
        r = '0;
        idx_use = idx_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                idx_use = '0;
                idx_next = '0;
            end
            default: ;
        endcase
        idx16 = 16'(idx_use);
        r.arg_index = idx16;
        case (phase_reg)
            PH_IDLE, PH_INLINE:
            begin
                if (phase_reg == PH_IDLE && q_item.is_star)
                begin
                    acc_next = '0; dseen_next = 1'b0; crp_next = 1'b0;
                    phase_next = PH_COUNT;
                end
                else if (phase_reg == PH_IDLE && !inline_enable)
                begin
                    emit = 1'b1; r.command_end = 1'b1; r.status = ST_PROTO;
                    phase_next = q_item.is_lf ? PH_IDLE : PH_SKIP;
                    crp_next = 1'b0;
                end
                else
                begin
                    logic hv, tk, lc;
                    hv = (phase_reg == PH_IDLE) ? 1'b0 : hv_reg;
                    tk = (phase_reg == PH_IDLE) ? 1'b0 : tok_reg;
                    lc = (phase_reg == PH_IDLE) ? 1'b0 : lhc_reg;
                    phase_next = PH_INLINE;
                    hv_next = hv; tok_next = tk; lhc_next = lc;
                    r.from_inline = 1'b1;
                    r.out_byte = fold(hb_reg, lowercase_name, idx_use == '0);
                    if (q_item.is_lf)
                    begin
                        emit = 1'b1; r.command_end = 1'b1;
                        if (hv && hb_reg != CH_CR)
                        begin
                            r.byte_valid = 1'b1; r.arg_end = 1'b1;
                        end
                        else if (tk) r.arg_end = 1'b1;
                        else if (!lc)
                        begin
                            r.status = ST_EMPTY; r.arg_index = '0;
                        end
                        if (!(hv && hb_reg != CH_CR)) r.out_byte = '0;
                        phase_next = PH_IDLE; hv_next = 1'b0;
                    end
                    else if (q_item.is_space)
                    begin
                        emit = 1'b1; r.arg_end = 1'b1; r.byte_valid = hv;
                        if (!hv) r.out_byte = '0;
                        if (idx_use != IDX_MAX) idx_next = idx_use + AI'(1);
                        hv_next = 1'b0; tok_next = 1'b0; lhc_next = 1'b1;
                    end
                    else
                    begin
                        if (hv)
                        begin
                            emit = 1'b1; r.byte_valid = 1'b1;
                            tok_next = 1'b1; lhc_next = 1'b1;
                        end
                        hb_next = b; hv_next = 1'b1;
                    end
                end
            end
            PH_COUNT, PH_LEN:
            begin
                logic bad; logic [1:0] st;
                bad = 1'b0; st = ST_PROTO;
                if (crp_reg)
                begin
                    if (!q_item.is_lf || !dseen_reg) bad = 1'b1;
                    else if (phase_reg == PH_COUNT)
                    begin
                        if (acc_reg == '0) bad = 1'b1;
                        else if ({2'b0, acc_reg} > climit)
                        begin
                            bad = 1'b1; st = ST_LARGE;
                        end
                        else
                        begin
                            crp_next = 1'b0; args_next = CW'(acc_reg);
                            idx_next = '0; phase_next = PH_DOLLAR;
                        end
                    end
                    else
                    begin
                        if (acc_reg > llimit)
                        begin
                            bad = 1'b1; st = ST_LARGE;
                        end
                        else
                        begin
                            crp_next = 1'b0; bytes_next = LENGTH_BITS'(acc_reg);
                            phase_next = (acc_reg == '0) ? PH_TAIL : PH_DATA;
                        end
                    end
                end
                else if (q_item.is_digit)
                begin
                    acc_next = (acc10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc10[30:0];
                    dseen_next = 1'b1;
                end
                else if (q_item.is_cr) crp_next = 1'b1;
                else bad = 1'b1;
                if (bad)
                begin
                    emit = 1'b1; r.command_end = 1'b1; r.status = st;
                    phase_next = q_item.is_lf ? PH_IDLE : PH_SKIP; crp_next = 1'b0;
                end
            end
            PH_DOLLAR:
            begin
                if (!q_item.is_dollar)
                begin
                    emit = 1'b1; r.command_end = 1'b1; r.status = ST_PROTO;
                    phase_next = q_item.is_lf ? PH_IDLE : PH_SKIP; crp_next = 1'b0;
                end
                else
                begin
                    acc_next = '0; dseen_next = 1'b0; crp_next = 1'b0;
                    phase_next = PH_LEN;
                end
            end
            PH_DATA:
            begin
                logic [LENGTH_BITS-1:0] nb;
                emit = 1'b1; r.byte_valid = 1'b1;
                r.out_byte = fold(b, lowercase_name, idx_reg == '0);
                nb = (bytes_reg != '0) ? bytes_reg - LENGTH_BITS'(1) : bytes_reg;
                bytes_next = nb;
                if (nb == '0)
                begin
                    crp_next = 1'b0; phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                if ((!crp_reg && !q_item.is_cr) || (crp_reg && !q_item.is_lf))
                begin
                    emit = 1'b1; r.command_end = 1'b1; r.status = ST_PROTO;
                    phase_next = q_item.is_lf ? PH_IDLE : PH_SKIP; crp_next = 1'b0;
                end
                else if (!crp_reg) crp_next = 1'b1;
                else
                begin
                    crp_next = 1'b0; emit = 1'b1; r.arg_end = 1'b1;
                    if (args_reg <= CW'(1))
                    begin
                        r.command_end = 1'b1; args_next = '0; phase_next = PH_IDLE;
                    end
                    else
                    begin
                        args_next = args_reg - CW'(1); idx_next = idx_reg + AI'(1);
                        phase_next = PH_DOLLAR;
                    end
                end
            end
            PH_SKIP:
            begin
                if (q_item.is_lf) phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (step && emit) o_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; acc_reg <= '0; dseen_reg <= 1'b0; args_reg <= '0;
            idx_reg <= '0; bytes_reg <= '0; crp_reg <= 1'b0; lhc_reg <= 1'b0;
            hv_reg <= 1'b0; hb_reg <= '0; tok_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next; acc_reg <= acc_next; dseen_reg <= dseen_next;
                args_reg <= args_next; idx_reg <= idx_next; bytes_reg <= bytes_next;
                crp_reg <= crp_next; lhc_reg <= lhc_next; hv_reg <= hv_next;
                hb_reg <= hb_next; tok_reg <= tok_next;
            end
            if (step) ov_reg <= emit;
            else if (res_ready) ov_reg <= 1'b0;
        end
    end
endmodule

// ===== sv/resp_command_deframer_top.sv =====
// ----------------------------------------------------------------------------
// resp_command_deframer_top
// request stream deframer: splits array and inline commands into arguments
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   tdata[7:0] in_byte
// m_axis   out  tdata: out_byte, arg_index, arg_end; tlast: command_end;
//               tuser: byte_valid, from_inline, status
// cfg      in   index 0..3, 30-bit data
// one byte per cycle sustained while m_axis_tready is high; the parser decides each byte combinationally
// a two-entry queue sits between front and parser, results are registered
// reset clears all state but queue slots and result data, and restores register defaults; no clearing pass
module resp_command_deframer_top
    import rcd_pkg::*;
#(
    parameter int ARG_INDEX_BITS = ARG_INDEX_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // in_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_byte, arg_index, arg_end
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,  // command_end
    // byte_valid, from_inline, status
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    `include "assert_macros.svh"

    logic        inl_reg, low_reg;
    logic [29:0] mlen_reg;
    logic [16:0] mcnt_reg;
    logic        q_valid, q_ready;
    cls_item_t   q_item;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inl_reg <= 1'b1; low_reg <= 1'b1;
            mlen_reg <= 30'd536870912; mcnt_reg <= 17'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INLINE: inl_reg <= cfg_data[0];
                CFG_LOWER:  low_reg <= cfg_data[0];
                CFG_MAXLEN: mlen_reg <= cfg_data;
                CFG_MAXCNT: mcnt_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    rcd_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    rcd_back #(.ARG_INDEX_BITS(ARG_INDEX_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .inline_enable(inl_reg), .lowercase_name(low_reg),
        .max_bulk_length(mlen_reg), .max_argument_count(mcnt_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {7'd0, res.arg_end, res.arg_index, res.out_byte};
    assign m_axis_tlast = res.command_end;
    assign m_axis_tuser = {res.status, res.from_inline, res.byte_valid};

    `ASSERT_IMPLIES(a_empty_no_byte, clk, rst_n,
        m_axis_tvalid && m_axis_tuser[3:2] == ST_EMPTY, !m_axis_tuser[0])
    `ASSERT_IMPLIES(a_err_ends_cmd, clk, rst_n,
        m_axis_tvalid && m_axis_tuser[3:2] != ST_OK, m_axis_tlast)
    `ASSERT_NEXT(a_hold_out, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(res))
endmodule
